@@ sv/mrtu_pkg.sv @@
package mrtu_pkg;

  // Receive buffer bound: bytes past this count are dropped.
  localparam int unsigned BUFFER_BYTES = 256;
  localparam int unsigned CountW       = $clog2(BUFFER_BYTES + 1);

  localparam int unsigned HeaderDepth = 6;
  localparam int unsigned IdleW       = 9;
  localparam logic [IdleW-1:0] IdleMax = '1;

  localparam int unsigned MinLength     = 3;
  localparam int unsigned RequestLength = 8;
  localparam logic [7:0]  FuncMin       = 8'd1;
  localparam logic [7:0]  FuncMax       = 8'd6;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK               = 3'd0,
    STATUS_IGNORED          = 3'd1,
    STATUS_CRC_ERROR        = 3'd2,
    STATUS_LENGTH_MISMATCH  = 3'd3,
    STATUS_ILLEGAL_FUNCTION = 3'd4
  } status_e;

  typedef logic [7:0] cfg_index_t;
  localparam cfg_index_t REG_DEVICE_ADDRESS = 8'd0;
  localparam cfg_index_t REG_SILENCE_LIMIT  = 8'd1;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [8:0]  frame_length;
  } verdict_t;

  // Modbus CRC-16, reflected, one byte.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/modbus_rtu_frame_receiver.sv @@
// Modbus RTU slave receive path. Each input transfer is either a line byte
// (operation 0) or a one-millisecond tick (operation 1). Bytes are counted up
// to the buffer bound of 256 (later bytes are dropped without touching the
// CRC or the idle counter), the first six are kept and each counted byte runs
// through the Modbus CRC-16. Ticks count idle time, saturating at 511. When a
// tick pushes the idle count above silence_limit while bytes are pending, one
// verdict transfer comes out and the receiver clears for the next frame.
// Verdict priority: ignored (three bytes or fewer, or foreign address), CRC
// error, illegal function (outside 1..6), length mismatch (not 8 bytes), ok.
// Timing: one input transfer per clock sustained when unstalled. A byte or
// tick is held in the input register and folded into the frame state once
// the output register can advance (one byte-wide CRC update is the longest
// path); a verdict it raises is loaded into the output register at that same
// edge. in_stall_o rises only while the input register holds an item and the
// output register is full and stalled. Config registers (index 0
// device_address, reset 1; index 1 silence_limit, reset 5) are always ready;
// other indexes are ignored. Write them only while the block is idle.
module modbus_rtu_frame_receiver (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  mrtu_pkg::cfg_index_t  cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_operation_i,
  input  logic [7:0]            in_rx_byte_i,
  // verdict channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            out_status_o,
  output logic [7:0]            out_function_code_o,
  output logic [15:0]           out_start_address_o,
  output logic [15:0]           out_quantity_or_value_o,
  output logic [8:0]            out_frame_length_o
);

  mrtu_pkg::cfg_t     cfg;
  logic               in_valid_q;
  mrtu_pkg::op_e      op_q;
  logic [7:0]         rx_byte_q;
  logic               advance;
  logic               step;
  logic               res_valid;
  mrtu_pkg::verdict_t res;
  logic               out_valid_q;
  mrtu_pkg::verdict_t out_q;

  mrtu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Output register can take a new verdict when empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q      <= mrtu_pkg::op_e'(in_operation_i);
      rx_byte_q <= in_rx_byte_i;
    end
  end

  mrtu_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .op_i        (op_q),
    .rx_byte_i   (rx_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_status_o            = out_q.status;
  assign out_function_code_o     = out_q.function_code;
  assign out_start_address_o     = out_q.start_address;
  assign out_quantity_or_value_o = out_q.quantity_or_value;
  assign out_frame_length_o      = out_q.frame_length;

  // verdicts only come from ticks
  a_verdict_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (step && op_q == mrtu_pkg::OP_TICK))
    else $error("verdict raised without a tick");

  // short frames are always ignored
  a_short_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_frame_length_o <= 9'd3)
      |-> (out_status_o == mrtu_pkg::STATUS_IGNORED))
    else $error("short frame not ignored");

  // an accepted request is exactly eight bytes with a legal function
  a_ok_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == mrtu_pkg::STATUS_OK)
      |-> (out_frame_length_o == 9'd8 && out_function_code_o >= 8'd1
           && out_function_code_o <= 8'd6))
    else $error("ok verdict with bad length or function");

  // stall only while an item is held and the verdict path is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

endmodule

@@ sv/mrtu_cfg_regs.sv @@
module mrtu_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  mrtu_pkg::cfg_index_t    cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  output mrtu_pkg::cfg_t          cfg_o
);

  mrtu_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= 8'd1;
      cfg_q.silence_limit  <= 8'd5;
    end else if (cfg_valid_i) begin
      // unknown indexes are dropped
      case (cfg_index_i)
        mrtu_pkg::REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data_i;
        mrtu_pkg::REG_SILENCE_LIMIT:  cfg_q.silence_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/mrtu_frame_core.sv @@
module mrtu_frame_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrtu_pkg::cfg_t       cfg_i,
  input  logic                 step_i,
  input  mrtu_pkg::op_e        op_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 res_valid_o,
  output mrtu_pkg::verdict_t   res_o
);

  localparam int unsigned CountW = mrtu_pkg::CountW;
  localparam int unsigned IdleW  = mrtu_pkg::IdleW;

  logic [CountW-1:0] byte_count_q;
  logic [7:0]        hdr_q [mrtu_pkg::HeaderDepth];
  logic [15:0]       crc_q;
  logic [IdleW-1:0]  idle_q;

  logic              byte_take;
  logic              tick_take;
  logic [IdleW-1:0]  idle_inc;
  logic              frame_done;
  mrtu_pkg::status_e status;

  assign byte_take = step_i && (op_i == mrtu_pkg::OP_BYTE)
                     && (byte_count_q < CountW'(mrtu_pkg::BUFFER_BYTES));
  assign tick_take = step_i && (op_i == mrtu_pkg::OP_TICK);

  assign idle_inc   = (idle_q < mrtu_pkg::IdleMax) ? idle_q + 1'b1 : idle_q;
  assign frame_done = tick_take && (idle_inc > {1'b0, cfg_i.silence_limit})
                      && (byte_count_q != '0);

  always_comb begin
    if ((byte_count_q <= CountW'(mrtu_pkg::MinLength))
        || (hdr_q[0] != cfg_i.device_address)) begin
      status = mrtu_pkg::STATUS_IGNORED;
    end else if (crc_q != 16'h0000) begin
      status = mrtu_pkg::STATUS_CRC_ERROR;
    end else if ((hdr_q[1] < mrtu_pkg::FuncMin) || (hdr_q[1] > mrtu_pkg::FuncMax)) begin
      status = mrtu_pkg::STATUS_ILLEGAL_FUNCTION;
    end else if (byte_count_q != CountW'(mrtu_pkg::RequestLength)) begin
      status = mrtu_pkg::STATUS_LENGTH_MISMATCH;
    end else begin
      status = mrtu_pkg::STATUS_OK;
    end
  end

  assign res_valid_o             = frame_done;
  assign res_o.status            = status;
  assign res_o.function_code     = hdr_q[1];
  assign res_o.start_address     = {hdr_q[2], hdr_q[3]};
  assign res_o.quantity_or_value = {hdr_q[4], hdr_q[5]};
  assign res_o.frame_length      = 9'(byte_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= mrtu_pkg::CrcInit;
      idle_q       <= '0;
      for (int i = 0; i < mrtu_pkg::HeaderDepth; i++) begin
        hdr_q[i] <= 8'h00;
      end
    end else if (frame_done) begin
      byte_count_q <= '0;
      crc_q        <= mrtu_pkg::CrcInit;
      idle_q       <= '0;
      for (int i = 0; i < mrtu_pkg::HeaderDepth; i++) begin
        hdr_q[i] <= 8'h00;
      end
    end else if (byte_take) begin
      for (int i = 0; i < mrtu_pkg::HeaderDepth; i++) begin
        if (byte_count_q == CountW'(i)) begin
          hdr_q[i] <= rx_byte_i;
        end
      end
      crc_q        <= mrtu_pkg::crc16_update(crc_q, rx_byte_i);
      byte_count_q <= byte_count_q + 1'b1;
      idle_q       <= '0;
    end else if (tick_take) begin
      idle_q <= idle_inc;
    end
  end

endmodule

@@ sim/modbus_verdict_checker.sv @@
package frame_crc_pkg;

  // Modbus CRC-16 over one byte, LSB first.
  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc,
                                                  input logic [7:0]  b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ mrtu_pkg::CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module modbus_verdict_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  mrtu_pkg::cfg_index_t cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 in_operation_i,
  input  logic [7:0]           in_rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [2:0]           out_status_i,
  input  logic [7:0]           out_function_code_i,
  input  logic [15:0]          out_start_address_i,
  input  logic [15:0]          out_quantity_or_value_i,
  input  logic [8:0]           out_frame_length_i,
  output int                   mismatches_o,
  output int                   awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CountW = mrtu_pkg::CountW;
  localparam int unsigned IdleW  = mrtu_pkg::IdleW;

  localparam logic [7:0] AddressAtReset = 8'd1;
  localparam logic [7:0] LimitAtReset   = 8'd5;

  logic [7:0]         own_address;
  logic [7:0]         quiet_limit;
  logic [CountW-1:0]  byte_tally;
  logic [7:0]         header_q [mrtu_pkg::HeaderDepth];
  logic [15:0]        crc_acc;
  logic [IdleW-1:0]   quiet_ticks;
  mrtu_pkg::verdict_t awaited_verdicts [$];
  int                 mismatch_count = 0;

  task automatic clear_frame();
    byte_tally  = '0;
    crc_acc     = mrtu_pkg::CrcInit;
    quiet_ticks = '0;
    for (int i = 0; i < mrtu_pkg::HeaderDepth; i++) begin
      header_q[i] = 8'h00;
    end
  endtask

  // Folds one line event into the frame state; a tick past the silence
  // limit with bytes pending yields a verdict.
  task automatic fold_line_event(input mrtu_pkg::op_e op, input logic [7:0] b);
    mrtu_pkg::verdict_t v;
    if (op == mrtu_pkg::OP_BYTE) begin
      if (byte_tally < CountW'(mrtu_pkg::BUFFER_BYTES)) begin
        if (byte_tally < CountW'(mrtu_pkg::HeaderDepth)) begin
          header_q[byte_tally[2:0]] = b;
        end
        crc_acc     = frame_crc_pkg::modbus_crc_next(crc_acc, b);
        byte_tally  = byte_tally + 1'b1;
        quiet_ticks = '0;
      end
    end else begin
      if (quiet_ticks != mrtu_pkg::IdleMax) begin
        quiet_ticks = quiet_ticks + 1'b1;
      end
      if (quiet_ticks > {1'b0, quiet_limit} && byte_tally != '0) begin
        if (byte_tally <= CountW'(mrtu_pkg::MinLength)
            || header_q[0] != own_address) begin
          v.status = mrtu_pkg::STATUS_IGNORED;
        end else if (crc_acc != 16'h0000) begin
          v.status = mrtu_pkg::STATUS_CRC_ERROR;
        end else if (header_q[1] < mrtu_pkg::FuncMin
                     || header_q[1] > mrtu_pkg::FuncMax) begin
          v.status = mrtu_pkg::STATUS_ILLEGAL_FUNCTION;
        end else if (byte_tally != CountW'(mrtu_pkg::RequestLength)) begin
          v.status = mrtu_pkg::STATUS_LENGTH_MISMATCH;
        end else begin
          v.status = mrtu_pkg::STATUS_OK;
        end
        v.function_code     = header_q[1];
        v.start_address     = {header_q[2], header_q[3]};
        v.quantity_or_value = {header_q[4], header_q[5]};
        v.frame_length      = byte_tally[8:0];
        awaited_verdicts.push_back(v);
        clear_frame();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("%0t: verdict %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mrtu_pkg::verdict_t want;
    if (!rst_ni) begin
      own_address = AddressAtReset;
      quiet_limit = LimitAtReset;
      clear_frame();
      awaited_verdicts.delete();
      mismatches_o <= 0;
      awaited_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mrtu_pkg::REG_DEVICE_ADDRESS: own_address = cfg_data_i;
          mrtu_pkg::REG_SILENCE_LIMIT:  quiet_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        fold_line_event(mrtu_pkg::op_e'(in_operation_i), in_rx_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch("transfer with none awaited", out_status_i, 16'h0);
        end else begin
          want = awaited_verdicts.pop_front();
          if (out_status_i !== want.status)
            report_mismatch("status", out_status_i, want.status);
          if (out_function_code_i !== want.function_code)
            report_mismatch("function_code", out_function_code_i, want.function_code);
          if (out_start_address_i !== want.start_address)
            report_mismatch("start_address", out_start_address_i, want.start_address);
          if (out_quantity_or_value_i !== want.quantity_or_value)
            report_mismatch("quantity_or_value", out_quantity_or_value_i,
                            want.quantity_or_value);
          if (out_frame_length_i !== want.frame_length)
            report_mismatch("frame_length", out_frame_length_i, want.frame_length);
        end
      end
      mismatches_o <= mismatch_count;
      awaited_o    <= awaited_verdicts.size();
    end
  end

endmodule

@@ sim/modbus_rtu_frame_receiver_test.sv @@
module modbus_rtu_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClockPeriod = 8;
  localparam int RunLimitNs  = 5_000_000;   // far beyond the slowest clean run

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  mrtu_pkg::cfg_index_t cfg_index_i = mrtu_pkg::REG_DEVICE_ADDRESS;
  logic [7:0]           cfg_data_i  = 8'h00;

  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        in_operation_i = mrtu_pkg::OP_BYTE;
  logic [7:0]  in_rx_byte_i   = 8'h00;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  out_status_o;
  logic [7:0]  out_function_code_o;
  logic [15:0] out_start_address_o;
  logic [15:0] out_quantity_or_value_o;
  logic [8:0]  out_frame_length_o;

  int          mismatches;
  int          awaited;

  // Stimulus-side copy of the config, used only to shape frames.
  logic [7:0]  cur_addr  = 8'd1;
  logic [7:0]  cur_limit = 8'd5;

  logic [7:0]  frame_q [$];       // bytes of the frame being built
  int          sent_items      = 0;
  int          burst_left      = 0;
  bit          sender_steady   = 1'b0;
  int          hold_off_cycles = 0;

  modbus_rtu_frame_receiver dut (.*);

  modbus_verdict_checker verdict_check (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_i             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_stall_i              (in_stall_o),
    .in_operation_i          (in_operation_i),
    .in_rx_byte_i            (in_rx_byte_i),
    .out_valid_i             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_status_i            (out_status_o),
    .out_function_code_i     (out_function_code_o),
    .out_start_address_i     (out_start_address_o),
    .out_quantity_or_value_i (out_quantity_or_value_o),
    .out_frame_length_i      (out_frame_length_o),
    .mismatches_o            (mismatches),
    .awaited_o               (awaited)
  );

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  // Verdict side: stall odds change from span to span (including long
  // stall-free spans); a hold-off request keeps the port stalled so the block
  // backs up into its input.
  initial begin : receiver
    int pct;
    int span;
    pct  = 0;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      if (span == 0) begin
        case ($urandom_range(3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 60;
          default: pct = 90;
        endcase
        span = $urandom_range(120, 20);
      end
      span--;
      out_stall_i <= ($urandom_range(99) < pct);
    end
  end

  initial begin
    #(RunLimitNs);
    $display("Some tests failed");
    $finish;
  end

  // One line event. Outside steady mode the sender runs in bursts with idle
  // gaps in between; within a burst valid stays high from transfer to
  // transfer.
  task automatic send_item(input mrtu_pkg::op_e op, input logic [7:0] b);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk_i);
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
    end
    in_valid_i     <= 1'b1;
    in_operation_i <= op;
    in_rx_byte_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(input mrtu_pkg::cfg_index_t idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Stop sending, let every predicted verdict come out, then give the block
  // time for a trailing byte still in its input register.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] addr, input logic [7:0] limit);
    settle();
    write_reg(mrtu_pkg::REG_DEVICE_ADDRESS, addr);
    write_reg(mrtu_pkg::REG_SILENCE_LIMIT, limit);
    cfg_valid_i <= 1'b0;
    cur_addr  = addr;
    cur_limit = limit;
  endtask

  task automatic header(input int n, input logic [7:0] b0, b1, b2, b3, b4, b5);
    logic [7:0] six [6];
    six = '{b0, b1, b2, b3, b4, b5};
    frame_q.delete();
    for (int i = 0; i < n; i++) begin
      frame_q.push_back(six[i]);
    end
  endtask

  // Modbus appends the CRC low byte first, so the residue comes out zero.
  task automatic add_crc();
    logic [15:0] acc;
    acc = mrtu_pkg::CrcInit;
    foreach (frame_q[i]) begin
      acc = mrtu_pkg::crc16_update(acc, frame_q[i]);
    end
    frame_q.push_back(acc[7:0]);
    frame_q.push_back(acc[15:8]);
  endtask

  // Sends the frame, sometimes with quiet spells short enough to keep it
  // open, then enough ticks to close it.
  task automatic transmit(input int pause_pct);
    foreach (frame_q[i]) begin
      if ($urandom_range(99) < pause_pct) begin
        repeat ($urandom_range(cur_limit)) begin
          send_item(mrtu_pkg::OP_TICK, 8'($urandom_range(255)));
        end
      end
      send_item(mrtu_pkg::OP_BYTE, frame_q[i]);
    end
    repeat (cur_limit + 1 + $urandom_range(2)) begin
      send_item(mrtu_pkg::OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  // Mostly well-formed requests to our own address; the rest has foreign
  // addresses, odd function codes, odd lengths, no CRC or a flipped bit.
  // A rare frame overruns the receive buffer.
  task automatic random_frame();
    int         shape;
    int         body;
    int         pick;
    logic [7:0] addr;
    logic [7:0] func;
    shape = $urandom_range(99);
    if (shape < 65) begin
      body = 6;
    end else if (shape < 90) begin
      body = $urandom_range(10);
    end else if (shape < 91) begin
      body = $urandom_range(300, 250);
    end else begin
      body = $urandom_range(4, 1);
    end
    addr = ($urandom_range(9) < 8) ? cur_addr : 8'($urandom_range(255));
    func = ($urandom_range(9) < 7)
           ? 8'($urandom_range(mrtu_pkg::FuncMax, mrtu_pkg::FuncMin))
           : 8'($urandom_range(255));
    frame_q.delete();
    for (int i = 0; i < body; i++) begin
      frame_q.push_back(i == 0 ? addr : i == 1 ? func : 8'($urandom_range(255)));
    end
    if ($urandom_range(9) < 8) begin
      add_crc();
    end
    if (frame_q.size() != 0 && $urandom_range(9) == 0) begin
      pick = $urandom_range(frame_q.size() - 1);
      frame_q[pick] = frame_q[pick] ^ 8'(1 << $urandom_range(7));
    end
  endtask

  // Frames plus some raw noise (loose bytes and ticks) until n more
  // transfers have gone in.
  task automatic run_random(input int n);
    int target;
    target = sent_items + n;
    while (sent_items < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(5, 1)) begin
          send_item(mrtu_pkg::op_e'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end else begin
        random_frame();
        transmit(10);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: address 1, limit 5.
    run_random(60);

    // Directed frames; with a limit of zero one tick closes a frame.
    configure(8'h11, 8'd0);
    send_item(mrtu_pkg::OP_TICK, 8'hFF);             // tick on an empty line
    header(1, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    transmit(0);                                     // lone byte: ignored
    header(6, 8'h11, 8'h03, 8'h00, 8'h6B, 8'h00, 8'h03);
    add_crc();
    transmit(0);                                     // proper read request
    header(2, 8'h11, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    add_crc();
    transmit(0);                                     // illegal function
    header(2, 8'h11, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00);
    add_crc();
    transmit(0);                                     // good CRC, short request
    header(2, 8'h11, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    add_crc();
    frame_q[3] = ~frame_q[3];
    transmit(0);                                     // CRC error

    // Address zero, no sender gaps.
    configure(8'h00, 8'd0);
    sender_steady = 1'b1;
    run_random(60);
    sender_steady = 1'b0;

    configure(8'hFF, 8'd1);
    run_random(60);

    // Park the verdict port while frames keep coming: the first verdict
    // sticks in the output register and the input backs up behind it.
    configure(8'($urandom_range(255)), 8'd2);
    hold_off_cycles = 400;
    repeat (6) begin
      random_frame();
      transmit(0);
    end

    // Widest limit: a long quiet line with nothing pending runs the idle
    // counter into saturation before any frame arrives.
    configure(8'($urandom_range(255)), 8'd255);
    repeat (600) send_item(mrtu_pkg::OP_TICK, 8'($urandom_range(255)));
    repeat (3) begin
      random_frame();
      transmit(10);
    end

    // Buffer overrun: bytes past the bound are dropped and do not reset
    // the idle count, so pauses among them add up.
    configure(8'($urandom_range(255)), 8'd3);
    header(2, cur_addr, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (268) frame_q.push_back(8'($urandom_range(255)));
    transmit(20);
    run_random(60);

    configure(8'($urandom_range(255)), 8'($urandom_range(7)));
    run_random(100);

    configure(8'($urandom_range(255)), 8'd4);
    sender_steady = 1'b1;
    run_random(60);
    sender_steady = 1'b0;

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
